@@ hw/rtl/slcd_pkg.sv @@
// types, constants and helper functions for the sync/length/checksum deframer
package slcd_pkg;

   localparam int MaxPayload = 512;
   localparam int LenW       = $clog2(MaxPayload);
   localparam int SyncLen    = 8;
   localparam int SyncIdxW   = $clog2(SyncLen);
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = QueuePtrW + 1;
   localparam int RspDataW   = 32;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_LEN0    = 4'd1,
      PH_LEN1    = 4'd2,
      PH_CK0     = 4'd3,
      PH_CK1     = 4'd4,
      PH_CK2     = 4'd5,
      PH_CK3     = 4'd6,
      PH_ID0     = 4'd7,
      PH_ID1     = 4'd8,
      PH_ID2     = 4'd9,
      PH_PAYLOAD = 4'd10
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_REPORT  = 1'b1
   } result_kind_type;

   typedef enum logic [1:0] {
      MSG_LWP   = 2'd0,
      MSG_STA   = 2'd1,
      MSG_OTHER = 2'd2
   } msg_kind_type;

   typedef struct packed {
      result_kind_type    kind;
      logic [7:0]         payload_byte;
      logic [LenW-1:0]    payload_index;
      logic               frame_good;
      msg_kind_type       message_kind;
      logic [LenW-1:0]    frame_length;
      logic               last_of_run;
   } result_type;

   // eight-character sync string, one character per match position
   function automatic logic [7:0] sync_char(input logic [SyncIdxW-1:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h50;
         3'd1:    c = 8'h43;
         3'd2:    c = 8'h55;
         3'd3:    c = 8'h49;
         3'd4:    c = 8'h5F;
         3'd5:    c = 8'h4D;
         3'd6:    c = 8'h53;
         default: c = 8'h47;
      endcase
      return c;
   endfunction

   function automatic msg_kind_type id_class(input logic [7:0] id0, input logic [7:0] id1,
                                             input logic [7:0] id2);
      msg_kind_type k;
      if (id0 == 8'h4C && id1 == 8'h57 && id2 == 8'h50) begin
         k = MSG_LWP;
      end else if (id0 == 8'h53 && id1 == 8'h54 && id2 == 8'h41) begin
         k = MSG_STA;
      end else begin
         k = MSG_OTHER;
      end
      return k;
   endfunction

endpackage

@@ hw/rtl/sync_length_checksum_deframer_top.sv @@
// sync-string hunter and length/checksum frame parser with a small result queue
//
//   port group  dir  contents
//   req_*       in   one received byte per transfer
//   rsp_*       out  payload byte or end-of-frame report per transfer
//
// one byte is taken per cycle while req_tready is high; its state update happens at the
// transfer edge and its results enter a four-entry queue; the first result is offered
// in the next cycle. the last payload byte gives two results, drained in turn from the queue.
// req_tready is low while the queue holds more than two results (only under rsp stalls).
// synchronous reset returns the parser to the sync hunt and empties the queue.
module sync_length_checksum_deframer_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] rx_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [7:0] payload_byte, [16:8] payload_index, [17] frame_good,
   // [19:18] message_kind, [28:20] frame_length, [31:29] zero
   output logic [slcd_pkg::RspDataW-1:0] rsp_tdata,
   output logic                         rsp_tuser,   // [0] result_kind
   output logic                         rsp_tlast    // [0] last_of_run
);

   localparam int LenW = slcd_pkg::LenW;

   slcd_pkg::phase_type              phase_ff, phase_in;
   logic [slcd_pkg::SyncIdxW-1:0]    sync_cnt_ff, sync_cnt_in;
   logic [LenW-1:0]                  len_ff, len_in;
   logic [31:0]                      chk_ff, chk_in;
   logic [31:0]                      sum_ff, sum_in;
   logic [7:0]                       id0_ff, id0_in;
   logic [7:0]                       id1_ff, id1_in;
   logic [7:0]                       id2_ff, id2_in;
   logic [LenW-1:0]                  count_ff, count_in;

   slcd_pkg::result_type             queue_ff [slcd_pkg::QueueDepth];
   logic [slcd_pkg::QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [slcd_pkg::QueueCntW-1:0]   q_cnt_ff, q_cnt_in;

   logic                             req_xfer, rsp_xfer;
   logic [7:0]                       b;
   logic [15:0]                      len_full;
   logic                             has_byte, frame_end;
   logic [LenW-1:0]                  count_step;
   logic [31:0]                      sum_step;
   slcd_pkg::result_type             pay_res, rep_res, res0, res1;
   logic                             push0, push1;
   logic [1:0]                       n_push;
   slcd_pkg::result_type             head;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   assign b        = req_tdata;
   assign len_full = {b, len_ff[7:0]};

   // payload phase arithmetic
   assign has_byte   = (count_ff < len_ff);
   assign count_step = count_ff + LenW'(has_byte);
   assign sum_step   = has_byte ? (sum_ff + {24'd0, b}) : sum_ff;
   assign frame_end  = (count_step == len_ff);

   always_comb begin
      pay_res               = '0;
      pay_res.kind          = slcd_pkg::KIND_PAYLOAD;
      pay_res.payload_byte  = b;
      pay_res.payload_index = count_ff;
      pay_res.message_kind  = slcd_pkg::MSG_LWP;
      pay_res.frame_length  = len_ff;
      pay_res.last_of_run   = !frame_end;

      rep_res               = '0;
      rep_res.kind          = slcd_pkg::KIND_REPORT;
      rep_res.frame_good    = (sum_step == chk_ff);
      rep_res.message_kind  = slcd_pkg::id_class(id0_ff, id1_ff, id2_ff);
      rep_res.frame_length  = len_ff;
      rep_res.last_of_run   = 1'b1;
   end

   always_comb begin
      phase_in    = phase_ff;
      sync_cnt_in = sync_cnt_ff;
      len_in      = len_ff;
      chk_in      = chk_ff;
      sum_in      = sum_ff;
      id0_in      = id0_ff;
      id1_in      = id1_ff;
      id2_in      = id2_ff;
      count_in    = count_ff;
      push0       = 1'b0;
      push1       = 1'b0;
      res0        = rep_res;
      res1        = rep_res;
      if (req_xfer) begin
         unique case (phase_ff)
            slcd_pkg::PH_HUNT: begin
               // a mismatching byte is not retried as a start character
               if (b == slcd_pkg::sync_char(sync_cnt_ff)) begin
                  sync_cnt_in = sync_cnt_ff + slcd_pkg::SyncIdxW'(1);
                  if (sync_cnt_ff == slcd_pkg::SyncIdxW'(slcd_pkg::SyncLen - 1)) begin
                     phase_in = slcd_pkg::PH_LEN0;
                  end
               end else begin
                  sync_cnt_in = '0;
               end
            end
            slcd_pkg::PH_LEN0: begin
               len_in   = LenW'(b);
               phase_in = slcd_pkg::PH_LEN1;
            end
            slcd_pkg::PH_LEN1: begin
               len_in   = len_full[LenW-1:0];
               phase_in = (len_full < 16'(slcd_pkg::MaxPayload)) ? slcd_pkg::PH_CK0
                                                                   : slcd_pkg::PH_HUNT;
            end
            slcd_pkg::PH_CK0: begin
               chk_in   = {24'd0, b};
               phase_in = slcd_pkg::PH_CK1;
            end
            slcd_pkg::PH_CK1: begin
               chk_in   = {chk_ff[31:16], b, chk_ff[7:0]};
               phase_in = slcd_pkg::PH_CK2;
            end
            slcd_pkg::PH_CK2: begin
               chk_in   = {chk_ff[31:24], b, chk_ff[15:0]};
               phase_in = slcd_pkg::PH_CK3;
            end
            slcd_pkg::PH_CK3: begin
               chk_in   = {b, chk_ff[23:0]};
               phase_in = slcd_pkg::PH_ID0;
            end
            slcd_pkg::PH_ID0: begin
               id0_in   = b;
               phase_in = slcd_pkg::PH_ID1;
            end
            slcd_pkg::PH_ID1: begin
               id1_in   = b;
               phase_in = slcd_pkg::PH_ID2;
            end
            slcd_pkg::PH_ID2: begin
               id2_in   = b;
               sum_in   = '0;
               count_in = '0;
               phase_in = slcd_pkg::PH_PAYLOAD;
            end
            slcd_pkg::PH_PAYLOAD: begin
               sum_in   = sum_step;
               count_in = count_step;
               // zero length: this byte is dropped and only the report goes out
               if (has_byte) begin
                  push0 = 1'b1;
                  res0  = pay_res;
                  push1 = frame_end;
               end else begin
                  push0 = frame_end;
               end
               if (frame_end) begin
                  phase_in = slcd_pkg::PH_HUNT;
               end
            end
            default: begin
               phase_in = slcd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   assign n_push   = {1'b0, push0} + {1'b0, push1};
   assign q_cnt_in = q_cnt_ff + slcd_pkg::QueueCntW'(n_push)
                     - slcd_pkg::QueueCntW'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= slcd_pkg::PH_HUNT;
         sync_cnt_ff <= '0;
         len_ff      <= '0;
         chk_ff      <= '0;
         sum_ff      <= '0;
         id0_ff      <= '0;
         id1_ff      <= '0;
         id2_ff      <= '0;
         count_ff    <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         q_cnt_ff    <= '0;
      end else begin
         phase_ff    <= phase_in;
         sync_cnt_ff <= sync_cnt_in;
         len_ff      <= len_in;
         chk_ff      <= chk_in;
         sum_ff      <= sum_in;
         id0_ff      <= id0_in;
         id1_ff      <= id1_in;
         id2_ff      <= id2_in;
         count_ff    <= count_in;
         wr_ptr_ff   <= wr_ptr_ff + slcd_pkg::QueuePtrW'(n_push);
         rd_ptr_ff   <= rd_ptr_ff + slcd_pkg::QueuePtrW'(rsp_xfer);
         q_cnt_ff    <= q_cnt_in;
      end
   end

   // result queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push1) begin
         queue_ff[wr_ptr_ff + slcd_pkg::QueuePtrW'(1)] <= res1;
      end
   end

   assign req_tready = (q_cnt_ff <= slcd_pkg::QueueCntW'(slcd_pkg::QueueDepth - 2));
   assign rsp_tvalid = (q_cnt_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last_of_run;
   assign rsp_tdata  = {3'd0, head.frame_length, head.message_kind, head.frame_good,
                        head.payload_index, head.payload_byte};

endmodule

@@ tb/sv/testbench.sv @@
// testbench for the sync/length/checksum deframer: directed table, random frames, self-checking
module testbench;
   import slcd_pkg::*;

   localparam int CycleLimit  = 400000;
   localparam int RandomBytes = 1950;
   localparam int HoldCycles  = 80;
   localparam int NumRows     = 55;

   localparam logic [7:0] SYNC_WORD [8] = '{"P", "C", "U", "I", "_", "M", "S", "G"};

   typedef struct {
      logic [7:0]   rx;
      bit           typed;
      logic         good;
      msg_kind_type kind;
   } stim_row_type;

   // typed rows carry the end report that the byte must produce
   stim_row_type directed_rows [NumRows] = '{
      // PP then CUI_MSG: the second P is not tried again as a start, so no sync
      '{"P", 1'b0, 1'b0, MSG_LWP}, '{"P", 1'b0, 1'b0, MSG_LWP}, '{"C", 1'b0, 1'b0, MSG_LWP},
      '{"U", 1'b0, 1'b0, MSG_LWP}, '{"I", 1'b0, 1'b0, MSG_LWP}, '{"_", 1'b0, 1'b0, MSG_LWP},
      '{"M", 1'b0, 1'b0, MSG_LWP}, '{"S", 1'b0, 1'b0, MSG_LWP}, '{"G", 1'b0, 1'b0, MSG_LWP},
      // full sync, length 0xffff is dropped
      '{"P", 1'b0, 1'b0, MSG_LWP}, '{"C", 1'b0, 1'b0, MSG_LWP}, '{"U", 1'b0, 1'b0, MSG_LWP},
      '{"I", 1'b0, 1'b0, MSG_LWP}, '{"_", 1'b0, 1'b0, MSG_LWP}, '{"M", 1'b0, 1'b0, MSG_LWP},
      '{"S", 1'b0, 1'b0, MSG_LWP}, '{"G", 1'b0, 1'b0, MSG_LWP},
      '{8'hFF, 1'b0, 1'b0, MSG_LWP}, '{8'hFF, 1'b0, 1'b0, MSG_LWP},
      // zero-length STA frame, checksum zero, next byte only ends it
      '{"P", 1'b0, 1'b0, MSG_LWP}, '{"C", 1'b0, 1'b0, MSG_LWP}, '{"U", 1'b0, 1'b0, MSG_LWP},
      '{"I", 1'b0, 1'b0, MSG_LWP}, '{"_", 1'b0, 1'b0, MSG_LWP}, '{"M", 1'b0, 1'b0, MSG_LWP},
      '{"S", 1'b0, 1'b0, MSG_LWP}, '{"G", 1'b0, 1'b0, MSG_LWP},
      '{8'h00, 1'b0, 1'b0, MSG_LWP}, '{8'h00, 1'b0, 1'b0, MSG_LWP},
      '{8'h00, 1'b0, 1'b0, MSG_LWP}, '{8'h00, 1'b0, 1'b0, MSG_LWP},
      '{8'h00, 1'b0, 1'b0, MSG_LWP}, '{8'h00, 1'b0, 1'b0, MSG_LWP},
      '{"S", 1'b0, 1'b0, MSG_LWP}, '{"T", 1'b0, 1'b0, MSG_LWP}, '{"A", 1'b0, 1'b0, MSG_LWP},
      '{8'hA5, 1'b1, 1'b1, MSG_STA},
      // one-byte LWP frame, payload 0xff against checksum 0xffffffff
      '{"P", 1'b0, 1'b0, MSG_LWP}, '{"C", 1'b0, 1'b0, MSG_LWP}, '{"U", 1'b0, 1'b0, MSG_LWP},
      '{"I", 1'b0, 1'b0, MSG_LWP}, '{"_", 1'b0, 1'b0, MSG_LWP}, '{"M", 1'b0, 1'b0, MSG_LWP},
      '{"S", 1'b0, 1'b0, MSG_LWP}, '{"G", 1'b0, 1'b0, MSG_LWP},
      '{8'h01, 1'b0, 1'b0, MSG_LWP}, '{8'h00, 1'b0, 1'b0, MSG_LWP},
      '{8'hFF, 1'b0, 1'b0, MSG_LWP}, '{8'hFF, 1'b0, 1'b0, MSG_LWP},
      '{8'hFF, 1'b0, 1'b0, MSG_LWP}, '{8'hFF, 1'b0, 1'b0, MSG_LWP},
      '{"L", 1'b0, 1'b0, MSG_LWP}, '{"W", 1'b0, 1'b0, MSG_LWP}, '{"P", 1'b0, 1'b0, MSG_LWP},
      '{8'hFF, 1'b1, 1'b0, MSG_LWP}
   };

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RspDataW-1:0] rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;

   // side notes travelling with each offered byte
   bit                  note_typed;
   logic                note_good;
   msg_kind_type        note_kind;

   // predictor state
   phase_type           parse_phase;
   logic [2:0]          sync_count;
   logic [15:0]         frame_len;
   logic [31:0]         rx_checksum;
   logic [31:0]         byte_sum;
   logic [7:0]          frame_id [3];
   logic [9:0]          byte_count;

   result_type          awaited_results [$];
   int                  error_count;
   int                  cycle_count;
   int                  bytes_sent;
   int                  big_frames;
   int                  req_idle_pct;
   int                  rsp_idle_pct;
   bit                  hold_request;
   int                  hold_left;

   sync_length_checksum_deframer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 40) begin
         $display("mismatch %s: got %0h, expected %0h", what, got, want);
      end
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   task automatic check_transfer;
      result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("result with nothing awaited", rsp_tdata, '0);
      end else begin
         want = awaited_results.pop_front();
         compare_field("result_kind", rsp_tuser, want.kind);
         compare_field("payload_byte", rsp_tdata[7:0], want.payload_byte);
         compare_field("payload_index", rsp_tdata[16:8], want.payload_index);
         compare_field("frame_good", rsp_tdata[17], want.frame_good);
         compare_field("message_kind", rsp_tdata[19:18], want.message_kind);
         compare_field("frame_length", rsp_tdata[28:20], want.frame_length);
         compare_field("padding", rsp_tdata[31:29], '0);
         compare_field("last_of_run", rsp_tlast, want.last_of_run);
      end
   endtask

   // frame parser: advances on one byte and queues the results it gives
   task automatic parse_rx_byte(input logic [7:0] b, input bit typed, input logic good,
                                input msg_kind_type kind);
      result_type pay_r;
      result_type end_r;
      bit         gave_pay;
      bit         gave_end;
      gave_pay = 1'b0;
      gave_end = 1'b0;
      pay_r    = '0;
      end_r    = '0;
      case (parse_phase)
         PH_HUNT: begin
            if (b == SYNC_WORD[sync_count]) begin
               if (sync_count == 3'd7) begin
                  sync_count  = 3'd0;
                  parse_phase = PH_LEN0;
               end else begin
                  sync_count = sync_count + 3'd1;
               end
            end else begin
               sync_count = 3'd0;
            end
         end
         PH_LEN0: begin
            frame_len   = {8'h00, b};
            parse_phase = PH_LEN1;
         end
         PH_LEN1: begin
            frame_len[15:8] = b;
            if (frame_len < MaxPayload) begin
               parse_phase = PH_CK0;
            end else begin
               parse_phase = PH_HUNT;
            end
         end
         PH_CK0: begin
            rx_checksum = {24'h000000, b};
            parse_phase = PH_CK1;
         end
         PH_CK1: begin
            rx_checksum[15:8] = b;
            parse_phase       = PH_CK2;
         end
         PH_CK2: begin
            rx_checksum[23:16] = b;
            parse_phase        = PH_CK3;
         end
         PH_CK3: begin
            rx_checksum[31:24] = b;
            parse_phase        = PH_ID0;
         end
         PH_ID0: begin
            frame_id[0] = b;
            parse_phase = PH_ID1;
         end
         PH_ID1: begin
            frame_id[1] = b;
            parse_phase = PH_ID2;
         end
         PH_ID2: begin
            frame_id[2] = b;
            byte_sum    = '0;
            byte_count  = '0;
            parse_phase = PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            if ({6'd0, byte_count} < frame_len) begin
               byte_sum            = byte_sum + {24'h000000, b};
               pay_r.kind          = KIND_PAYLOAD;
               pay_r.payload_byte  = b;
               pay_r.payload_index = byte_count[LenW-1:0];
               pay_r.frame_length  = frame_len[LenW-1:0];
               pay_r.last_of_run   = 1'b1;
               gave_pay            = 1'b1;
               byte_count          = byte_count + 10'd1;
            end
            if ({6'd0, byte_count} == frame_len) begin
               end_r.kind         = KIND_REPORT;
               end_r.frame_good   = (byte_sum == rx_checksum);
               end_r.frame_length = frame_len[LenW-1:0];
               end_r.last_of_run  = 1'b1;
               if ({frame_id[0], frame_id[1], frame_id[2]} == "LWP") begin
                  end_r.message_kind = MSG_LWP;
               end else if ({frame_id[0], frame_id[1], frame_id[2]} == "STA") begin
                  end_r.message_kind = MSG_STA;
               end else begin
                  end_r.message_kind = MSG_OTHER;
               end
               if (typed) begin
                  end_r.frame_good   = good;
                  end_r.message_kind = kind;
               end
               pay_r.last_of_run = 1'b0;
               gave_end          = 1'b1;
               parse_phase       = PH_HUNT;
            end
         end
         default: begin
            parse_phase = PH_HUNT;
         end
      endcase
      if (gave_pay) begin
         awaited_results.push_back(pay_r);
      end
      if (gave_end) begin
         awaited_results.push_back(end_r);
      end
   endtask

   // results are checked before the byte of the same edge is parsed
   always @(posedge clock) begin
      if (reset) begin
         parse_phase = PH_HUNT;
         sync_count  = '0;
         frame_len   = '0;
         rx_checksum = '0;
         byte_sum    = '0;
         frame_id    = '{8'h00, 8'h00, 8'h00};
         byte_count  = '0;
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_transfer();
         end
         if (req_tvalid && req_tready) begin
            parse_rx_byte(req_tdata, note_typed, note_good, note_kind);
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      hold_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HoldCycles - 1;
            rsp_tready  <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input logic good = 1'b0, input msg_kind_type kind = MSG_LWP);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      note_typed <= typed;
      note_good  <= good;
      note_kind  <= kind;
      do begin
         @(posedge clock);
      end while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (awaited_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic send_frame;
      int          pick;
      int          n;
      logic [15:0] len;
      logic [31:0] sum;
      logic [31:0] ck;
      logic [7:0]  payload [MaxPayload];
      logic [23:0] id;
      pick = $urandom_range(99);
      if (pick < 8) begin
         // line noise
         n = $urandom_range(1, 6);
         repeat (n) send_byte(8'($urandom_range(255)));
      end else if (pick < 14) begin
         // sync string cut short
         n = $urandom_range(1, 7);
         for (int i = 0; i < n; i++) begin
            send_byte(SYNC_WORD[i]);
         end
         send_byte(8'($urandom_range(255)));
      end else begin
         for (int i = 0; i < 8; i++) begin
            send_byte(SYNC_WORD[i]);
         end
         if (pick < 19) begin
            // oversized length, frame dropped
            send_byte(8'($urandom_range(255)));
            send_byte(8'($urandom_range(2, 255)));
         end else begin
            pick = $urandom_range(99);
            if (pick < 86) begin
               len = 16'($urandom_range(0, 24));
            end else if (pick < 97 || big_frames >= 3) begin
               len = 16'($urandom_range(25, 300));
            end else begin
               len = 16'(MaxPayload - 1);
               big_frames++;
            end
            sum = '0;
            for (int i = 0; i < len; i++) begin
               payload[i] = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom_range(255));
               sum        = sum + {24'h000000, payload[i]};
            end
            pick = $urandom_range(9);
            if (pick < 5) begin
               ck = sum;
            end else if (pick < 7) begin
               ck = sum ^ (32'd1 << $urandom_range(31));
            end else begin
               ck = $urandom();
            end
            case ($urandom_range(3))
               0:       id = "LWP";
               1:       id = "STA";
               2: begin
                  // near miss on one of the known ids
                  id = $urandom_range(1) ? "LWP" : "STA";
                  id[8*$urandom_range(2) +: 8] = 8'($urandom_range(255));
               end
               default: id = 24'($urandom());
            endcase
            send_byte(len[7:0]);
            send_byte(len[15:8]);
            for (int i = 0; i < 4; i++) begin
               send_byte(ck[8*i +: 8]);
            end
            send_byte(id[23:16]);
            send_byte(id[15:8]);
            send_byte(id[7:0]);
            if (len == 0) begin
               send_byte(8'($urandom_range(255)));
            end else begin
               for (int i = 0; i < len; i++) begin
                  send_byte(payload[i]);
               end
            end
         end
      end
   endtask

   initial begin
      int frame_no;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      note_typed   = 1'b0;
      note_good    = 1'b0;
      note_kind    = MSG_LWP;
      error_count  = 0;
      cycle_count  = 0;
      bytes_sent   = 0;
      big_frames   = 0;
      hold_request = 1'b0;
      req_idle_pct = 34;
      rsp_idle_pct = 34;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].good,
                   directed_rows[i].kind);
      end

      frame_no = 0;
      while (bytes_sent < NumRows + RandomBytes) begin
         // a stretch with no random stalls on either side
         if (frame_no >= 30 && frame_no < 55) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            req_idle_pct = 34;
            rsp_idle_pct = 34;
         end
         if (frame_no == 12 || frame_no == 45) begin
            hold_request = 1'b1;
         end
         if (frame_no == 25) begin
            wait_for_drain();
         end
         send_frame();
         frame_no++;
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/slcd_pkg.sv
hw/rtl/sync_length_checksum_deframer_top.sv
tb/sv/testbench.sv
